// ===== design/ilir_pkg.sv =====
package ilir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int WIDTH_DEF    = 32;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 3'd0,
        KIND_SET    = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_REMOVE = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // per-transaction command broadcast to every cell
    typedef struct packed {
        logic do_set;
        logic do_ins;
        logic do_rem;
    } t_cell_ctl;

endpackage

// ===== design/indexed_list_insert_remove.sv =====
// Positional list of up to CAPACITY words held in a row of cells, one entry per cell.
// Every transaction is get, set, insert, remove, clear or a no-op; all cells compare
// their own index with the position and load, shift up or shift down in the same clock,
// so one transaction is taken every cycle and its result appears in the output register
// in the cycle after acceptance. The input stalls only while that register holds an
// untaken result. Status reports bad index before list full; clear only zeroes the count.
module indexed_list_insert_remove #(
    parameter int CAPACITY = ilir_pkg::CAPACITY_DEF,
    parameter int WIDTH    = ilir_pkg::WIDTH_DEF,
    parameter int POS_W    = $clog2(CAPACITY + 1),
    parameter int IN_W     = ((POS_W + WIDTH + 7) / 8) * 8,
    parameter int OUT_W    = ((2 + WIDTH + POS_W + 1 + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [IN_W-1:0]             i_s_tdata,   // position, write_value
    input  logic [ilir_pkg::KIND_W-1:0] i_s_tuser,   // kind
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [OUT_W-1:0]            o_m_tdata    // status, read_value, count, empty_res
);
    import ilir_pkg::*;

    logic [POS_W-1:0] in_pos;
    logic [WIDTH-1:0] in_val;
    logic             accept;

    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] n_count;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    t_cell_ctl        ctl;
    t_status          status;
    logic             want_rd;
    logic [WIDTH-1:0] rd_val;
    logic [WIDTH-1:0] cell_val [CAPACITY];
    logic [WIDTH-1:0] cell_rd  [CAPACITY];

    assign in_pos = i_s_tdata[POS_W-1:0];
    assign in_val = i_s_tdata[POS_W+WIDTH-1:POS_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        ctl     = '0;
        status  = ST_OK;
        want_rd = 1'b0;
        n_count = r_count;
        unique case (t_kind'(i_s_tuser))
            KIND_GET: begin
                if (in_pos >= r_count) begin
                    status = ST_BAD_INDEX;
                end else begin
                    want_rd = 1'b1;
                end
            end
            KIND_SET: begin
                if (in_pos >= r_count) begin
                    status = ST_BAD_INDEX;
                end else begin
                    ctl.do_set = accept;
                end
            end
            KIND_INSERT: begin
                if (in_pos > r_count) begin
                    status = ST_BAD_INDEX;
                end else if (r_count == POS_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else begin
                    ctl.do_ins = accept;
                    n_count    = r_count + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (in_pos >= r_count) begin
                    status = ST_BAD_INDEX;
                end else begin
                    want_rd    = 1'b1;
                    ctl.do_rem = accept;
                    n_count    = r_count - 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WIDTH-1:0] lower;
        logic [WIDTH-1:0] upper;
        if (g == 0) begin : g_bot
            assign lower = in_val;
        end else begin : g_mid_lo
            assign lower = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign upper = cell_val[g];
        end else begin : g_mid_hi
            assign upper = cell_val[g+1];
        end
        ilir_cell #(
            .WIDTH (WIDTH),
            .POS_W (POS_W),
            .IDX   (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_pos    (in_pos),
            .i_wr_val (in_val),
            .i_lower  (lower),
            .i_upper  (upper),
            .o_val    (cell_val[g]),
            .o_rd     (cell_rd[g])
        );
    end

    // only the addressed cell drives a nonzero term
    always_comb begin
        rd_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_val = rd_val | cell_rd[k];
        end
        if (!want_rd) begin
            rd_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= OUT_W'({(n_count == '0), n_count, rd_val, status});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== design/ilir_cell.sv =====
module ilir_cell #(
    parameter int WIDTH = 32,
    parameter int POS_W = 5,
    parameter int IDX   = 0
) (
    input  logic               i_clk,
    input  ilir_pkg::t_cell_ctl i_ctl,
    input  logic [POS_W-1:0]   i_pos,
    input  logic [WIDTH-1:0]   i_wr_val,
    input  logic [WIDTH-1:0]   i_lower,
    input  logic [WIDTH-1:0]   i_upper,
    output logic [WIDTH-1:0]   o_val,
    output logic [WIDTH-1:0]   o_rd
);
    import ilir_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] n_val;
    logic             hit;
    logic             above;

    assign hit   = (i_pos == MY_IDX);
    assign above = (MY_IDX > i_pos);

    always_comb begin
        n_val = r_val;
        if (i_ctl.do_set && hit) begin
            n_val = i_wr_val;
        end
        if (i_ctl.do_ins) begin
            // entries at and above the position move up one place
            if (hit) begin
                n_val = i_wr_val;
            end else if (above) begin
                n_val = i_lower;
            end
        end
        if (i_ctl.do_rem && (hit || above)) begin
            n_val = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = hit ? r_val : '0;

endmodule

// ===== tb/tb.sv =====
module tb;
    import ilir_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int POS_W     = $clog2(CAP + 1);
    localparam int IN_W      = ((POS_W + WIDTH_DEF + 7) / 8) * 8;
    localparam int OUT_W     = ((2 + WIDTH_DEF + POS_W + 1 + 7) / 8) * 8;
    localparam int NUM_OPS   = 1900;
    localparam int QUIET_MAX = 1000;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} t_phase_mode;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [WIDTH_DEF-1:0] rd;
        logic [POS_W-1:0]     cnt;
        logic                 empty;
    } t_list_result;

    // list model plus the queue of results it predicts
    class list_scoreboard;
        logic [WIDTH_DEF-1:0] cells [CAP];
        int                   held;
        t_list_result         pending_results [$];
        int                   errors;
        int                   checked;
        int                   noted;
        int                   kind_hits [8];
        int                   bad_hits;
        int                   full_hits;
        int                   peak;

        function new();
            held    = 0;
            errors  = 0;
            checked = 0;
            noted   = 0;
            bad_hits  = 0;
            full_hits = 0;
            peak      = 0;
            foreach (kind_hits[i]) kind_hits[i] = 0;
        endfunction

        function void note_op(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                              logic [WIDTH_DEF-1:0] v);
            t_list_result r;
            int           i;
            r.status = ST_OK;
            r.rd     = '0;
            case (k)
                KIND_GET: begin
                    if (p >= held) r.status = ST_BAD_INDEX;
                    else r.rd = cells[p];
                end
                KIND_SET: begin
                    if (p >= held) r.status = ST_BAD_INDEX;
                    else cells[p] = v;
                end
                KIND_INSERT: begin
                    if (p > held) begin
                        r.status = ST_BAD_INDEX;
                    end else if (held >= CAP) begin
                        r.status = ST_FULL;
                    end else begin
                        for (i = held; i > p; i--) cells[i] = cells[i-1];
                        cells[p] = v;
                        held++;
                    end
                end
                KIND_REMOVE: begin
                    if (p >= held) begin
                        r.status = ST_BAD_INDEX;
                    end else begin
                        r.rd = cells[p];
                        for (i = p; i + 1 < held; i++) cells[i] = cells[i+1];
                        held--;
                    end
                end
                KIND_CLEAR: held = 0;
                default: ;
            endcase
            r.cnt   = held[POS_W-1:0];
            r.empty = (held == 0);
            if (r.status == ST_BAD_INDEX) bad_hits++;
            if (r.status == ST_FULL) full_hits++;
            if (held > peak) peak = held;
            kind_hits[k]++;
            noted++;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
            $display("mismatch on result %0d, %s: got %0h, wanted %0h",
                     checked, what, got, want_v);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] d);
            t_list_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", d[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (d[1:0] !== want.status)
                    report_mismatch("status", 32'(d[1:0]), 32'(want.status));
                if (d[2 +: WIDTH_DEF] !== want.rd)
                    report_mismatch("read_value", d[2 +: WIDTH_DEF], want.rd);
                if (d[2+WIDTH_DEF +: POS_W] !== want.cnt)
                    report_mismatch("count", 32'(d[2+WIDTH_DEF +: POS_W]), 32'(want.cnt));
                if (d[2+WIDTH_DEF+POS_W] !== want.empty)
                    report_mismatch("empty_res", 32'(d[2+WIDTH_DEF+POS_W]),
                                    32'(want.empty));
            end
            checked++;
        endtask
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_W-1:0]   i_s_tdata  = '0;   // position, write_value
    logic [KIND_W-1:0] i_s_tuser  = '0;   // kind
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_tdata;         // status, read_value, count, empty_res

    list_scoreboard board;
    bit             no_idle = 1'b0;
    int             stall_left = 0;
    int             quiet = 0;

    indexed_list_insert_remove dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_op(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                           logic [WIDTH_DEF-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= k;
        i_s_tdata  <= {{(IN_W-POS_W-WIDTH_DEF){1'b0}}, v, p};
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        board.note_op(k, p, v);
    endtask

    // weighted operation choice, positions mostly inside the live range
    task automatic send_random_op(t_phase_mode mode);
        logic [KIND_W-1:0]    k;
        logic [POS_W-1:0]     p;
        logic [WIDTH_DEF-1:0] v;
        int                   r;
        int                   n;
        r = $urandom_range(0, 99);
        n = board.held;
        if (r < 4) begin
            k = KIND_W'($urandom_range(KIND_CLEAR + 1, (1 << KIND_W) - 1));
        end else begin
            case (mode)
                PH_FILL:
                    k = (r < 64) ? KIND_INSERT : (r < 76) ? KIND_GET :
                        (r < 88) ? KIND_SET : (r < 98) ? KIND_REMOVE : KIND_CLEAR;
                PH_DRAIN:
                    k = (r < 54) ? KIND_REMOVE : (r < 70) ? KIND_GET :
                        (r < 82) ? KIND_SET : (r < 98) ? KIND_INSERT : KIND_CLEAR;
                default:
                    k = (r < 32) ? KIND_INSERT : (r < 54) ? KIND_REMOVE :
                        (r < 74) ? KIND_GET : (r < 96) ? KIND_SET : KIND_CLEAR;
            endcase
        end
        if ($urandom_range(0, 99) < 85) begin
            if (k == KIND_INSERT) p = POS_W'($urandom_range(0, n));
            else p = POS_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
        end else begin
            p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        end
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
        endcase
        send_op(k, p, v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata);
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            i_m_tready <= (stall_left == 0);
        end
    end

    // ends a run that hangs
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_phase_mode mode;
        int          len;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: every indexed access is out of range
        send_op(KIND_GET,    0, 32'h0);
        send_op(KIND_REMOVE, 0, 32'h0);
        send_op(KIND_SET,    0, 32'h1111_1111);
        send_op(KIND_INSERT, 1, 32'h2222_2222);
        send_op(KIND_INSERT, 31, 32'hFFFF_FFFF);
        // inserts at back, front and middle
        send_op(KIND_INSERT, 0, 32'h0000_0000);
        send_op(KIND_INSERT, 1, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 0, 32'hA5A5_A5A5);
        send_op(KIND_INSERT, 1, 32'h5A5A_5A5A);
        send_op(KIND_GET,    3, 32'h0);
        send_op(KIND_GET,    4, 32'h0);
        send_op(KIND_SET,    4, 32'h3333_3333);
        send_op(KIND_SET,    1, 32'h1234_5678);
        send_op(KIND_GET,    1, 32'h0);
        send_op(KIND_REMOVE, 1, 32'h0);
        send_op(KIND_REMOVE, 2, 32'h0);
        // kinds with no operation leave the list alone
        for (int u = KIND_CLEAR + 1; u < (1 << KIND_W); u++)
            send_op(KIND_W'(u), POS_W'($urandom), $urandom);
        send_op(KIND_CLEAR,  17, 32'hDEAD_BEEF);
        send_op(KIND_GET,    0, 32'h0);
        send_op(KIND_INSERT, 0, 32'h8000_0001);
        send_op(KIND_REMOVE, 0, 32'h0);
        send_op(KIND_CLEAR,  0, 32'h0);

        while (board.noted < NUM_OPS) begin
            mode    = t_phase_mode'($urandom_range(0, 2));
            len     = $urandom_range(40, 150);
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (len) send_random_op(mode);
            // a filled list must also answer full at both ends and bad index just past the end
            if (mode == PH_FILL && board.held == CAP) begin
                send_op(KIND_INSERT, POS_W'(CAP), $urandom);
                send_op(KIND_INSERT, 0, $urandom);
                send_op(KIND_INSERT, POS_W'(CAP + 1), $urandom);
            end
        end

        i_s_tvalid <= 1'b0;
        no_idle = 1'b1;
        while (board.pending_results.size() > 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("ran %0d operations: get %0d, set %0d, insert %0d, remove %0d, clear %0d, other %0d",
                 board.noted, board.kind_hits[KIND_GET], board.kind_hits[KIND_SET],
                 board.kind_hits[KIND_INSERT], board.kind_hits[KIND_REMOVE],
                 board.kind_hits[KIND_CLEAR],
                 board.noted - board.kind_hits[KIND_GET] - board.kind_hits[KIND_SET]
                 - board.kind_hits[KIND_INSERT] - board.kind_hits[KIND_REMOVE]
                 - board.kind_hits[KIND_CLEAR]);
        $display("bad index %0d times, list full %0d times, peak count %0d, %0d mismatches",
                 board.bad_hits, board.full_hits, board.peak, board.errors);
        if (board.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
